>>> design/lacd_pkg.sv
// Shared constants and types for the LRU age cache directory.
package lacd_pkg;

  localparam int KEY_IN_W = 64;  // key port width
  localparam int SIZE_W   = 17;  // object size width
  localparam int SLOT_W   = 3;   // slot result width

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_SAVE   = 1'b1;

  // Scan token flags passed from cell to cell.
  typedef struct packed {
    logic valid;    // token present in this stage
    logic matched;  // a filled cell upstream held the key
  } scan_ctl_t;

endpackage

>>> design/lacd_cell.sv
// One directory cell: holds tag, age and size of one entry, plus one scan token stage.
module lacd_cell #(
  parameter int KEY_WIDTH  = 64,
  parameter int AGE_WIDTH  = 16,
  parameter int IDX_W      = 3,
  parameter int CELL_INDEX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      filled,
  input  logic [KEY_WIDTH-1:0]      req_tag,
  input  logic                      req_save,
  input  lacd_pkg::scan_ctl_t       ctl_in,
  input  logic [IDX_W-1:0]          hit_idx_in,
  input  logic [lacd_pkg::SIZE_W-1:0] hit_size_in,
  input  logic [AGE_WIDTH-1:0]      best_age_in,
  input  logic [IDX_W-1:0]          best_idx_in,
  output lacd_pkg::scan_ctl_t       ctl_out,
  output logic [IDX_W-1:0]          hit_idx_out,
  output logic [lacd_pkg::SIZE_W-1:0] hit_size_out,
  output logic [AGE_WIDTH-1:0]      best_age_out,
  output logic [IDX_W-1:0]          best_idx_out,
  input  logic                      wr_en,
  input  logic [KEY_WIDTH-1:0]      wr_tag,
  input  logic [lacd_pkg::SIZE_W-1:0] wr_size
);
  import lacd_pkg::*;

  logic [KEY_WIDTH-1:0] tag_r,  tag_nxt;
  logic [AGE_WIDTH-1:0] age_r,  age_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  scan_ctl_t            ctl_r,  ctl_nxt;
  logic [IDX_W-1:0]     hit_idx_r,  hit_idx_nxt;
  logic [SIZE_W-1:0]    hit_size_r, hit_size_nxt;
  logic [AGE_WIDTH-1:0] best_age_r, best_age_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [AGE_WIDTH-1:0] age_inc;

  // saturating age step
  assign age_inc = (age_r == {AGE_WIDTH{1'b1}}) ? age_r : age_r + AGE_WIDTH'(1);

  always_comb begin
    tag_nxt      = tag_r;
    size_nxt     = size_r;
    age_nxt      = age_r;
    ctl_nxt      = ctl_in;
    hit_idx_nxt  = hit_idx_in;
    hit_size_nxt = hit_size_in;
    best_age_nxt = best_age_in;
    best_idx_nxt = best_idx_in;
    if (ctl_in.valid && filled && !ctl_in.matched) begin
      if (tag_r == req_tag) begin
        ctl_nxt.matched = 1'b1;
        hit_idx_nxt     = IDX_W'(CELL_INDEX);
        hit_size_nxt    = size_r;
        if (req_save) begin
          age_nxt = '0;
        end
      end else if (req_save) begin
        age_nxt = age_inc;
        // strict compare keeps the lowest index on ties
        if (age_inc > best_age_in) begin
          best_age_nxt = age_inc;
          best_idx_nxt = IDX_W'(CELL_INDEX);
        end
      end
    end
    if (wr_en) begin
      tag_nxt  = wr_tag;
      size_nxt = wr_size;
      age_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    age_r      <= age_nxt;
    size_r     <= size_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_size_r <= hit_size_nxt;
    best_age_r <= best_age_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign ctl_out      = ctl_r;
  assign hit_idx_out  = hit_idx_r;
  assign hit_size_out = hit_size_r;
  assign best_age_out = best_age_r;
  assign best_idx_out = best_idx_r;

endmodule

>>> design/lru_age_cache_directory_unit.sv
// Top level of the LRU age cache directory: request intake, cell chain, fill/replace, result.
// An input transfer registers the request and launches the scan token; the token walks
//   the cell chain one cell per cycle, the result is settled in the pending registers, then
//   it is moved to the output register once that is free. No new request is taken until then.
// Reset (synchronous, rst_n low): fill count cleared, chain empty, no result pending.
//   Entry tags, ages and sizes are not cleared; only filled entries are ever read.
module lru_age_cache_directory_unit #(
  parameter int ENTRIES          = 8,
  parameter int KEY_WIDTH        = 64,
  parameter int AGE_WIDTH        = 16,
  parameter int OBJECT_BYTES_MAX = 102400
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [lacd_pkg::KEY_IN_W-1:0] in_key,
  input  logic [lacd_pkg::SIZE_W-1:0]   in_object_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [lacd_pkg::SLOT_W-1:0]   out_slot,
  output logic [lacd_pkg::SIZE_W-1:0]   out_stored_size
);
  import lacd_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int SAT_W  = 21;  // wide enough for the largest size limit
  localparam logic [SAT_W-1:0] SIZE_LIMIT = SAT_W'(OBJECT_BYTES_MAX);

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic                 start_r, start_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;

  // request held for the whole scan
  logic [KEY_WIDTH-1:0] req_tag_r, req_tag_nxt;
  logic                 req_save_r, req_save_nxt;
  logic [SIZE_W-1:0]    req_size_r, req_size_nxt;

  // result waiting for the output register
  logic                 pend_hit_r, pend_hit_nxt;
  logic [SLOT_W-1:0]    pend_slot_r, pend_slot_nxt;
  logic [SIZE_W-1:0]    pend_size_r, pend_size_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [SIZE_W-1:0]    out_size_r, out_size_nxt;

  logic                 in_xfer;
  logic                 out_free;
  logic                 full;
  logic [SIZE_W-1:0]    size_sat;

  // links of the cell chain: link 0 is the token source, link i+1 leaves cell i
  scan_ctl_t            lnk_ctl      [ENTRIES+1];
  logic [IDX_W-1:0]     lnk_hit_idx  [ENTRIES+1];
  logic [SIZE_W-1:0]    lnk_hit_size [ENTRIES+1];
  logic [AGE_WIDTH-1:0] lnk_best_age [ENTRIES+1];
  logic [IDX_W-1:0]     lnk_best_idx [ENTRIES+1];
  logic [ENTRIES-1:0]   filled_vec;
  logic [ENTRIES-1:0]   wr_en_vec;
  logic [ENTRIES:0]     tok_vec;

  scan_ctl_t            tail_ctl;
  logic                 wr_go;
  logic [IDX_W-1:0]     victim;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (fill_r == FILL_W'(ENTRIES));

  // oversized objects are clamped to the limit
  assign size_sat = (SAT_W'(in_object_size) > SIZE_LIMIT) ? SIZE_LIMIT[SIZE_W-1:0]
                                                           : in_object_size;

  // token source
  assign lnk_ctl[0].valid   = start_r;
  assign lnk_ctl[0].matched = 1'b0;
  assign lnk_hit_idx[0]     = '0;
  assign lnk_hit_size[0]    = '0;
  assign lnk_best_age[0]    = '0;
  assign lnk_best_idx[0]    = '0;

  assign tail_ctl = lnk_ctl[ENTRIES];

  // save miss: next free slot, else the oldest lowest-index entry
  assign victim = full ? lnk_best_idx[ENTRIES] : fill_r[IDX_W-1:0];
  assign wr_go  = (state_r == S_SCAN) && tail_ctl.valid && req_save_r && !tail_ctl.matched;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      assign filled_vec[gi] = (FILL_W'(gi) < fill_r);
      assign wr_en_vec[gi]  = wr_go && (victim == IDX_W'(gi));
      assign tok_vec[gi+1]  = lnk_ctl[gi+1].valid;

      lacd_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .AGE_WIDTH (AGE_WIDTH),
        .IDX_W     (IDX_W),
        .CELL_INDEX(gi)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .filled      (filled_vec[gi]),
        .req_tag     (req_tag_r),
        .req_save    (req_save_r),
        .ctl_in      (lnk_ctl[gi]),
        .hit_idx_in  (lnk_hit_idx[gi]),
        .hit_size_in (lnk_hit_size[gi]),
        .best_age_in (lnk_best_age[gi]),
        .best_idx_in (lnk_best_idx[gi]),
        .ctl_out     (lnk_ctl[gi+1]),
        .hit_idx_out (lnk_hit_idx[gi+1]),
        .hit_size_out(lnk_hit_size[gi+1]),
        .best_age_out(lnk_best_age[gi+1]),
        .best_idx_out(lnk_best_idx[gi+1]),
        .wr_en       (wr_en_vec[gi]),
        .wr_tag      (req_tag_r),
        .wr_size     (req_size_r)
      );
    end
  endgenerate

  assign tok_vec[0] = start_r;

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    fill_nxt      = fill_r;
    req_tag_nxt   = req_tag_r;
    req_save_nxt  = req_save_r;
    req_size_nxt  = req_size_r;
    pend_hit_nxt  = pend_hit_r;
    pend_slot_nxt = pend_slot_r;
    pend_size_nxt = pend_size_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    out_size_nxt  = out_size_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_tag_nxt  = in_key[KEY_WIDTH-1:0];
          req_save_nxt = (in_operation == OP_SAVE);
          req_size_nxt = size_sat;
          start_nxt    = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // token leaves the last cell: settle the result and any fill/replace
        if (tail_ctl.valid) begin
          if (tail_ctl.matched) begin
            pend_hit_nxt  = 1'b1;
            pend_slot_nxt = SLOT_W'(lnk_hit_idx[ENTRIES]);
            pend_size_nxt = lnk_hit_size[ENTRIES];
          end else if (req_save_r) begin
            pend_hit_nxt  = 1'b0;
            pend_slot_nxt = SLOT_W'(victim);
            pend_size_nxt = req_size_r;
            if (!full) begin
              fill_nxt = fill_r + FILL_W'(1);
            end
          end else begin
            pend_hit_nxt  = 1'b0;
            pend_slot_nxt = '0;
            pend_size_nxt = '0;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = pend_hit_r;
          out_slot_nxt  = pend_slot_r;
          out_size_nxt  = pend_size_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_tag_r   <= req_tag_nxt;
    req_save_r  <= req_save_nxt;
    req_size_r  <= req_size_nxt;
    pend_hit_r  <= pend_hit_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_size_r <= pend_size_nxt;
    out_hit_r   <= out_hit_nxt;
    out_slot_r  <= out_slot_nxt;
    out_size_r  <= out_size_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_stored_size = out_size_r;

  // fill count never passes the entry count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(ENTRIES))
    else $error("fill count above entry count");

  // only one scan token in the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vec) <= 1)
    else $error("more than one scan token in flight");

  // a token reaches the end of the chain only during a scan
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail_ctl.valid |-> (state_r == S_SCAN))
    else $error("scan token outside scan state");

  // an input transfer launches a token next cycle
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> start_r)
    else $error("transfer did not launch a scan");

  // lookups and save hits leave the fill count alone
  a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_ctl.valid && (!req_save_r || tail_ctl.matched)) |=> $stable(fill_r))
    else $error("fill count changed without a save miss");

endmodule
